FILE: sv/mtas_pkg.sv
// Package: constants, types and state codes shared by the keystream scrambler files.
`default_nettype none

package mtas_pkg;

  // Sample width default and generator geometry
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MT_N            = 624;
  localparam int MT_M            = 397;
  localparam int PTR_W           = 10;
  localparam int KEY_W           = 30;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  // Twister constants
  localparam logic [31:0] SEED_MULT = 32'd1812433253;
  localparam logic [31:0] MATRIX_A  = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

  // Fixed-point scale factors, Q1.31
  localparam logic [31:0] K19  = 32'd4080218931;
  localparam logic [31:0] N095 = 32'd2040109465;
  localparam logic [26:0] K005 = 27'd107374182;

  // Register indexes
  typedef enum logic [0:0] {
    REG_KEY_SEED     = 1'b0,
    REG_DECRYPT_MODE = 1'b1
  } reg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED0,
    ST_SMUL,
    ST_SADD,
    ST_TWA,
    ST_TWB,
    ST_MUL,
    ST_FIN
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic seed_init;
    logic seed_mul;
    logic seed_add;
    logic twist;
    logic scale;
    logic mul;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic seed_last;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/mtas_regs.sv
// APB register bank: key seed and mode.
`default_nettype none

module mtas_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel_i,
  input  wire logic                            penable_i,
  input  wire logic                            pwrite_i,
  input  wire logic [mtas_pkg::APB_ADDR_W-1:0] paddr_i,
  input  wire logic [mtas_pkg::APB_DATA_W-1:0] pwdata_i,
  output logic      [mtas_pkg::APB_DATA_W-1:0] prdata_o,
  output logic                                 pready_o,
  output logic      [mtas_pkg::KEY_W-1:0]      key_seed_o,
  output logic                                 decrypt_mode_o
);
  import mtas_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic             mode_q, mode_d;
  logic             wr_en;
  reg_idx_e         idx;

  assign wr_en = psel_i & penable_i & pwrite_i & pready_o;
  assign idx   = reg_idx_e'(paddr_i[2]);

  always_comb begin
    key_d  = key_q;
    mode_d = mode_q;
    if (wr_en) begin
      unique case (idx)
        REG_KEY_SEED:     key_d  = pwdata_i[KEY_W-1:0];
        REG_DECRYPT_MODE: mode_d = pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      mode_q <= 1'b0;
    end else begin
      key_q  <= key_d;
      mode_q <= mode_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_SEED:     prdata_o = APB_DATA_W'(key_q);
      REG_DECRYPT_MODE: prdata_o = APB_DATA_W'(mode_q);
      default:          prdata_o = '0;
    endcase
  end

  assign pready_o       = 1'b1;
  assign key_seed_o     = key_q;
  assign decrypt_mode_o = mode_q;

endmodule

`default_nettype wire

FILE: sv/mtas_ctrl.sv
// Controller: sequences seeding, the two draws, the noise multiply and result hand-off.
`default_nettype none

module mtas_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_restart_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire mtas_pkg::status_t status_i,
  output mtas_pkg::cmd_t         cmd_o
);
  import mtas_pkg::*;

  state_e state_q, state_d;
  logic   seeded_q, seeded_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_restart_i || !seeded_q) ? ST_SEED0 : ST_TWA;
        end
      end
      ST_SEED0: state_d = ST_SMUL;
      ST_SMUL:  state_d = ST_SADD;
      ST_SADD:  state_d = status_i.seed_last ? ST_TWA : ST_SMUL;
      ST_TWA:   state_d = ST_TWB;
      ST_TWB:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_SEED0: cmd_o.seed_init = 1'b1;
      ST_SMUL:  cmd_o.seed_mul  = 1'b1;
      ST_SADD:  cmd_o.seed_add  = 1'b1;
      ST_TWA: begin
        cmd_o.twist = 1'b1;
        cmd_o.scale = 1'b1;
      end
      ST_TWB:   cmd_o.twist = 1'b1;
      ST_MUL:   cmd_o.mul   = 1'b1;
      ST_FIN:   cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    seeded_d = seeded_q;
    if (state_q == ST_SADD && status_i.seed_last) begin
      seeded_d = 1'b1;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A restart, or any word before the first seed, must go through seeding
  a_restart_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_restart_i || !seeded_q)) |=> state_q == ST_SEED0)
    else $error("restart did not enter seeding");

  // The second draw always follows the first directly
  a_twb_after_twa: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TWB) |-> $past(state_q) == ST_TWA)
    else $error("second draw without first");

  // The first draw only starts from idle or at the end of seeding
  a_twa_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TWA) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_SADD))
    else $error("draw entered from wrong state");

  // A generated word is presented the cycle after it is loaded
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (out_valid_q && seeded_q))
    else $error("loaded word not presented");

endmodule

`default_nettype wire

FILE: sv/mtas_dp.sv
// Datapath: twister state memory, seeding, lazy twist and tempering, noise and mixing arithmetic.
`default_nettype none

module mtas_dp #(
  parameter int SAMPLE_BITS = mtas_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire mtas_pkg::cmd_t              cmd_i,
  output mtas_pkg::status_t                status_o,
  input  wire logic [mtas_pkg::KEY_W-1:0]  key_seed_i,
  input  wire logic                        decrypt_mode_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0]    sample_o,
  output logic                             clipped_o
);
  import mtas_pkg::*;

  localparam int F   = SAMPLE_BITS - 1;
  localparam int NW  = SAMPLE_BITS + 1;   // noise
  localparam int DW  = SAMPLE_BITS + 2;   // decrypt difference
  localparam int RW  = SAMPLE_BITS + 7;   // raw result
  localparam int SKW = SAMPLE_BITS + 28;  // scaled sample product
  localparam int EW  = SKW - 31;
  localparam logic [SAMPLE_BITS-1:0] NOISE_OFS = SAMPLE_BITS'(N095 >> (32 - SAMPLE_BITS));
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-F){1'b0}}, {F{1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-F){1'b1}}, {F{1'b0}}};
  localparam logic signed [27:0]   K005_S = {1'b0, K005};

  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] p, logic [PTR_W-1:0] k);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, k};
    if (s >= (PTR_W+1)'(MT_N)) s = s - (PTR_W+1)'(MT_N);
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [31:0] temper(logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic [31:0]      mem_q [MT_N];
  logic [31:0]      rd1_q, rd2_q;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [PTR_W-1:0] idx_q;
  logic [31:0]      seed_w_q, seed_prod_q, seed_next;
  logic [31:0]      cache_q, draw_q;
  logic [31:0]      tw_y, tw_v;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SKW-1:0] sk_q;
  logic [63:0]      prod_q, prod_full;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [31:0]      wdata;

  logic signed [NW-1:0] noise;
  logic signed [EW-1:0] enc_part;
  logic signed [DW-1:0] dec_diff;
  logic signed [RW-1:0] enc_r, dec_r, raw_r, sat_r;
  logic                 clip;

  assign seed_next = seed_prod_q + 32'(idx_q);
  assign status_o.seed_last = (idx_q == PTR_W'(MT_N - 1));

  // Advance the read pointer
  always_comb begin
    if (cmd_i.seed_init) begin
      ptr_d = '0;
    end else if (cmd_i.twist) begin
      ptr_d = ptr_add(ptr_q, PTR_W'(1));
    end else begin
      ptr_d = ptr_q;
    end
  end

  // Twist of the word at the pointer, from the cached word and the two reads
  assign tw_y = {cache_q[31], rd1_q[30:0]};
  assign tw_v = rd2_q ^ {1'b0, tw_y[31:1]} ^ (tw_y[0] ? MATRIX_A : 32'd0);

  always_comb begin
    we    = cmd_i.seed_init | cmd_i.seed_add | cmd_i.twist;
    waddr = ptr_q;
    wdata = tw_v;
    if (cmd_i.seed_init) begin
      waddr = '0;
      wdata = 32'(key_seed_i);
    end else if (cmd_i.seed_add) begin
      waddr = idx_q;
      wdata = seed_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd1_q <= mem_q[ptr_add(ptr_d, PTR_W'(1))];
    rd2_q <= mem_q[ptr_add(ptr_d, PTR_W'(MT_M))];
  end

  assign prod_full = K19 * draw_q;

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
    if (cmd_i.seed_init) begin
      seed_w_q <= 32'(key_seed_i);
      cache_q  <= 32'(key_seed_i);
      idx_q    <= PTR_W'(1);
    end
    if (cmd_i.seed_mul) begin
      seed_prod_q <= SEED_MULT * (seed_w_q ^ (seed_w_q >> 30));
    end
    if (cmd_i.seed_add) begin
      seed_w_q <= seed_next;
      idx_q    <= idx_q + PTR_W'(1);
    end
    if (cmd_i.twist) begin
      cache_q <= rd1_q;
      draw_q  <= temper(tw_v);
    end
    if (cmd_i.scale) begin
      sk_q <= sample_q * K005_S;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full;
    end
    if (cmd_i.load_out) begin
      sample_o  <= sat_r[SAMPLE_BITS-1:0];
      clipped_o <= clip;
    end
  end

  // Noise, mix and saturate
  always_comb begin
    noise    = $signed({1'b0, prod_q[63 -: SAMPLE_BITS]}) - $signed({1'b0, NOISE_OFS});
    enc_part = sk_q[SKW-1:31];
    enc_r    = RW'(enc_part) + RW'(noise);
    dec_diff = DW'(sample_q) - DW'(noise);
    dec_r    = (RW'(dec_diff) <<< 4) + (RW'(dec_diff) <<< 2);
    raw_r    = decrypt_mode_i ? dec_r : enc_r;
    if (raw_r > SAT_HI) begin
      sat_r = SAT_HI;
      clip  = 1'b1;
    end else if (raw_r < SAT_LO) begin
      sat_r = SAT_LO;
      clip  = 1'b1;
    end else begin
      sat_r = raw_r;
      clip  = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mt19937_audio_scrambler_unit.sv
// Top level: keystream audio scrambler with stream ports and APB register port.
//
//   channel      dir   handshake             payload
//   s_axis       in    tvalid/tready         tdata: sample_in; tuser: restart
//   m_axis       out   tvalid/tready         tdata: sample_out; tuser: clipped
//   apb          in    psel/penable/pready   key_seed (0x0), decrypt_mode (0x4)
//
// A sample word is taken when the unit is idle; tvalid rises once the finish
// step has loaded the output register. The steps are accept, first draw, second
// draw, noise multiply and finish; the two draws depend on each other through the
// state memory. A new word is taken only once the unit is idle again. A word with
// restart, or the first word after reset, first seeds the generator: a start
// step, then a seed multiply and an add step for each later state word.
// Reset clears control state only; the twister memory is never cleared, since
// the first word always seeds it. A finished word waits in the output register
// while the next word is accepted; the finish step holds if that register is full.
`default_nettype none

module mt19937_audio_scrambler_unit #(
  parameter int  SAMPLE_BITS = mtas_pkg::SAMPLE_BITS_DEF,
  localparam int TDW         = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [TDW-1:0]                  s_axis_tdata_i,  // [SAMPLE_BITS-1:0] sample_in
  input  wire logic                            s_axis_tuser_i,  // [0] restart
  // Output stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic      [TDW-1:0]                  m_axis_tdata_o,  // [SAMPLE_BITS-1:0] sample_out
  output logic                                 m_axis_tuser_o,  // [0] clipped
  // Register port
  input  wire logic                            psel_i,
  input  wire logic                            penable_i,
  input  wire logic                            pwrite_i,
  input  wire logic [mtas_pkg::APB_ADDR_W-1:0] paddr_i,
  input  wire logic [mtas_pkg::APB_DATA_W-1:0] pwdata_i,
  output logic      [mtas_pkg::APB_DATA_W-1:0] prdata_o,
  output logic                                 pready_o
);
  import mtas_pkg::*;

  cmd_t                          cmd;
  status_t                       status;
  logic [KEY_W-1:0]              key_seed;
  logic                          decrypt_mode;
  logic [SAMPLE_BITS-1:0]        sample_out;

  // Configuration registers
  mtas_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel_i),
    .penable_i      (penable_i),
    .pwrite_i       (pwrite_i),
    .paddr_i        (paddr_i),
    .pwdata_i       (pwdata_i),
    .prdata_o       (prdata_o),
    .pready_o       (pready_o),
    .key_seed_o     (key_seed),
    .decrypt_mode_o (decrypt_mode)
  );

  // Sequencer: owns the handshakes and the seeded flag
  mtas_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_restart_i (s_axis_tuser_i),
    .in_ready_o   (s_axis_tready_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Generator state, draws and sample arithmetic
  mtas_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .key_seed_i     (key_seed),
    .decrypt_mode_i (decrypt_mode),
    .sample_i       ($signed(s_axis_tdata_i[SAMPLE_BITS-1:0])),
    .sample_o       (sample_out),
    .clipped_o      (m_axis_tuser_o)
  );

  // Zero-pad the sample up to whole bytes
  assign m_axis_tdata_o = TDW'(sample_out);

endmodule

`default_nettype wire
